[hdl/wpm_pkg.sv]
// shared types and fixed widths for the windowed point mean block
`timescale 1ns / 1ps

package wpm_pkg;

    // coordinate width and outlier radius width
    localparam int PT_W = 16;
    localparam int R_W  = 16;

    // one 3d point, 0.1 mm units
    typedef struct packed {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic signed [PT_W-1:0] z;
    } t_point;

endpackage

[hdl/windowed_point_mean_outlier_reject_core.sv]
// top level: point window chain, outlier test pipeline and inlier mean dividers
`timescale 1ns / 1ps

// Keeps the last WINDOW points in a chain of cells and emits the mean of the
// points lying within outlier_radius of the window mean.
// Input channel: i_valid / o_stall with i_point_x, i_point_y, i_point_z. A word
// is taken when i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with the inlier mean, count and flag.
// Config: i_cfg_we writes i_cfg_data into outlier_radius (reset value 500).
// The first WINDOW words only fill the chain and give no result; o_stall
// stays low while they are taken. After that every word gives one result
// word: the chain rotates once to sum the window, rotates once more through
// the distance pipeline, the pipeline drains, the bit-serial dividers run
// and the result goes to the output register. The dividers are skipped when
// no point is an inlier. o_stall stays high during that time, so one word
// is in work at a time and the next word can be taken once the result is
// loaded into the output register. The output register holds a result
// while i_stall is high; a new word may be taken meanwhile and waits at its
// end for the register to free.
// Reset empties the window, drops any pending result and restores the radius.
module windowed_point_mean_outlier_reject_core #(
    parameter int WINDOW = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wpm_pkg::R_W-1:0]             i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [wpm_pkg::PT_W-1:0]     i_point_x,
    input  logic signed [wpm_pkg::PT_W-1:0]     i_point_y,
    input  logic signed [wpm_pkg::PT_W-1:0]     i_point_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [wpm_pkg::PT_W-1:0]     o_mean_x,
    output logic signed [wpm_pkg::PT_W-1:0]     o_mean_y,
    output logic signed [wpm_pkg::PT_W-1:0]     o_mean_z,
    output logic [$clog2(WINDOW+1)-1:0]         o_inlier_count,
    output logic                                o_all_inliers
);
    import wpm_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int SUM_W  = PT_W + $clog2(WINDOW);
    localparam int DIFF_W = SUM_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int D2_W   = SQ_W + 2;
    localparam int NR_W   = R_W + CNT_W;
    localparam int LIM_W  = 2 * NR_W;
    localparam int CMP_W  = (D2_W > LIM_W) ? D2_W : LIM_W;

    localparam logic signed [SUM_W-1:0] C_N = SUM_W'(WINDOW);

    localparam int         ST_W    = 3;
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_TEST  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [ST_W-1:0]  r_state;
    logic [ST_W-1:0]  n_state;
    logic [CNT_W-1:0] r_fill;
    logic [IDX_W-1:0] r_idx;
    logic [R_W-1:0]   r_radius;
    logic [NR_W-1:0]  r_nr;
    logic [LIM_W-1:0] r_lim;

    logic signed [SUM_W-1:0] r_sx, r_sy, r_sz;
    logic signed [SUM_W-1:0] r_ix, r_iy, r_iz;
    logic [CNT_W-1:0]        r_icnt;

    logic                     r_s1_v;
    logic signed [DIFF_W-1:0] r_s1_dx, r_s1_dy, r_s1_dz;
    t_point                   r_s1_pt;
    logic                     r_s2_v;
    logic [SQ_W-1:0]          r_s2_sqx, r_s2_sqy, r_s2_sqz;
    t_point                   r_s2_pt;

    logic                    r_out_valid;
    logic signed [PT_W-1:0]  r_mx, r_my, r_mz;
    logic [CNT_W-1:0]        r_ocnt;
    logic                    r_oall;

    t_point                   w_link [WINDOW+1];
    t_point                   w_tail;
    logic                     w_accept;
    logic                     w_shift;
    logic                     w_last;
    logic                     w_drained;
    logic                     w_out_load;
    logic                     w_div_start;
    logic                     w_div_done;
    logic                     w_done_x, w_done_y, w_done_z;
    logic signed [SUM_W-1:0]  w_qx, w_qy, w_qz;
    logic signed [SUM_W-1:0]  w_npx, w_npy, w_npz;
    logic signed [SQ_W-1:0]   w_sqx, w_sqy, w_sqz;
    logic [D2_W-1:0]          w_d2;
    logic                     w_inl;

    // handshake and sequencing conditions
    assign o_stall     = (r_state != S_IDLE);
    assign w_accept    = i_valid && !o_stall;
    assign w_shift     = w_accept || (r_state == S_SUM) || (r_state == S_TEST);
    assign w_last      = (r_idx == IDX_W'(WINDOW - 1));
    assign w_drained   = !r_s1_v && !r_s2_v;
    assign w_out_load  = (r_state == S_OUT) && (!r_out_valid || !i_stall);
    assign w_div_start = (r_state == S_DRAIN) && w_drained && (r_icnt != '0);
    assign w_div_done  = w_done_x && w_done_y && w_done_z;

    // head of the chain takes the new word, or the tail while rotating
    assign w_link[0] = (r_state == S_IDLE) ? t_point'{x: i_point_x, y: i_point_y, z: i_point_z}
                                           : w_tail;
    assign w_tail    = w_link[WINDOW];

    // window cells, oldest point at the tail
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        wpm_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_pt    (w_link[g]),
            .o_pt    (w_link[g+1])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (r_fill == CNT_W'(WINDOW))) n_state = S_SUM;
            end
            S_SUM: begin
                if (w_last) n_state = S_TEST;
            end
            S_TEST: begin
                if (w_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (w_drained) n_state = (r_icnt == '0) ? S_OUT : S_DIV;
            end
            S_DIV: begin
                if (w_div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_idx       <= '0;
            r_radius    <= R_W'(500);
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_radius <= i_cfg_data;
            end
            if (w_accept && (r_fill != CNT_W'(WINDOW))) begin
                r_fill <= r_fill + CNT_W'(1);
            end
            if (w_accept) begin
                r_idx <= '0;
            end else if ((r_state == S_SUM) || (r_state == S_TEST)) begin
                r_idx <= w_last ? '0 : r_idx + IDX_W'(1);
            end
            r_s1_v <= (r_state == S_TEST);
            r_s2_v <= r_s1_v;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // window sum and scaled squared radius
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sx <= '0;
            r_sy <= '0;
            r_sz <= '0;
            r_nr <= NR_W'(r_radius) * NR_W'(WINDOW);
        end else if (r_state == S_SUM) begin
            r_sx  <= r_sx + SUM_W'(w_tail.x);
            r_sy  <= r_sy + SUM_W'(w_tail.y);
            r_sz  <= r_sz + SUM_W'(w_tail.z);
            r_lim <= LIM_W'(r_nr) * LIM_W'(r_nr);
        end
    end

    // stage 1: scaled offset from the window mean
    assign w_npx = SUM_W'(w_tail.x) * C_N;
    assign w_npy = SUM_W'(w_tail.y) * C_N;
    assign w_npz = SUM_W'(w_tail.z) * C_N;

    always_ff @(posedge i_clk) begin
        r_s1_dx <= DIFF_W'(w_npx) - DIFF_W'(r_sx);
        r_s1_dy <= DIFF_W'(w_npy) - DIFF_W'(r_sy);
        r_s1_dz <= DIFF_W'(w_npz) - DIFF_W'(r_sz);
        r_s1_pt <= w_tail;
    end

    // stage 2: squares per axis
    assign w_sqx = SQ_W'(r_s1_dx) * SQ_W'(r_s1_dx);
    assign w_sqy = SQ_W'(r_s1_dy) * SQ_W'(r_s1_dy);
    assign w_sqz = SQ_W'(r_s1_dz) * SQ_W'(r_s1_dz);

    always_ff @(posedge i_clk) begin
        r_s2_sqx <= w_sqx;
        r_s2_sqy <= w_sqy;
        r_s2_sqz <= w_sqz;
        r_s2_pt  <= r_s1_pt;
    end

    // stage 3: distance test and inlier sums
    assign w_d2  = D2_W'(r_s2_sqx) + D2_W'(r_s2_sqy) + D2_W'(r_s2_sqz);
    assign w_inl = (CMP_W'(w_d2) < CMP_W'(r_lim));

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ix   <= '0;
            r_iy   <= '0;
            r_iz   <= '0;
            r_icnt <= '0;
        end else if (r_s2_v && w_inl) begin
            r_ix   <= r_ix + SUM_W'(r_s2_pt.x);
            r_iy   <= r_iy + SUM_W'(r_s2_pt.y);
            r_iz   <= r_iz + SUM_W'(r_s2_pt.z);
            r_icnt <= r_icnt + CNT_W'(1);
        end
    end

    // inlier mean dividers, one per axis
    wpm_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_ix),
        .i_divisor  (r_icnt),
        .o_done     (w_done_x),
        .o_quot     (w_qx)
    );

    wpm_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_iy),
        .i_divisor  (r_icnt),
        .o_done     (w_done_y),
        .o_quot     (w_qy)
    );

    wpm_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_z (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_iz),
        .i_divisor  (r_icnt),
        .o_done     (w_done_z),
        .o_quot     (w_qz)
    );

    // output register, zeros when nothing is an inlier
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_mx   <= (r_icnt == '0) ? '0 : w_qx[PT_W-1:0];
            r_my   <= (r_icnt == '0) ? '0 : w_qy[PT_W-1:0];
            r_mz   <= (r_icnt == '0) ? '0 : w_qz[PT_W-1:0];
            r_ocnt <= r_icnt;
            r_oall <= (r_icnt == CNT_W'(WINDOW));
        end
    end

    assign o_valid        = r_out_valid;
    assign o_mean_x       = r_mx;
    assign o_mean_y       = r_my;
    assign o_mean_z       = r_mz;
    assign o_inlier_count = r_ocnt;
    assign o_all_inliers  = r_oall;

    // fill count saturates at the window size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(WINDOW))
        else $error("fill count beyond window size");

    // dividers only finish while the sequencer waits for them
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    // empty inlier set gives an all-zero mean
    a_zero_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_inlier_count == '0)) |->
            ((o_mean_x == '0) && (o_mean_y == '0) && (o_mean_z == '0) && !o_all_inliers))
        else $error("nonzero mean with no inliers");

    // all-inliers flag agrees with the count
    a_all_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_all_inliers == (o_inlier_count == CNT_W'(WINDOW))))
        else $error("all-inliers flag disagrees with count");

endmodule

[hdl/wpm_cell.sv]
// one window cell: holds a point and hands it to the next cell on shift
`timescale 1ns / 1ps

module wpm_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  wpm_pkg::t_point i_pt,
    output wpm_pkg::t_point o_pt
);
    import wpm_pkg::*;

    t_point r_pt;

    // take the neighbor's point on every shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_pt <= i_pt;
        end
    end

    assign o_pt = r_pt;

endmodule

[hdl/wpm_div.sv]
// iterative signed-by-unsigned divider, one quotient bit per cycle, truncates toward zero
`timescale 1ns / 1ps

module wpm_div #(
    parameter int DVD_W = 19,
    parameter int DVS_W = 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DVD_W-1:0] i_dividend,
    input  logic        [DVS_W-1:0] i_divisor,
    output logic                    o_done,
    output logic signed [DVD_W-1:0] o_quot
);
    localparam int CW = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_div;
    logic             r_neg;

    logic [DVS_W:0]   w_sh;
    logic [DVS_W:0]   w_trial;
    logic             w_qbit;
    logic [DVS_W-1:0] w_rem;

    // restoring step on the magnitude
    assign w_sh    = {r_rem, r_q[DVD_W-1]};
    assign w_trial = w_sh - {1'b0, r_div};
    assign w_qbit  = !w_trial[DVS_W];
    assign w_rem   = w_qbit ? w_trial[DVS_W-1:0] : w_sh[DVS_W-1:0];

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend magnitude, remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend[DVD_W-1] ? DVD_W'(-i_dividend) : DVD_W'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[DVD_W-1];
        end else if (r_busy) begin
            r_rem <= w_rem;
            r_q   <= {r_q[DVD_W-2:0], w_qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? DVD_W'(-r_q) : DVD_W'(r_q);

endmodule

[tb/sv/tb_windowed_point_mean_outlier_reject_core.sv]
// self-checking testbench for the windowed point mean core with outlier rejection
`timescale 1ns / 1ps

module tb_windowed_point_mean_outlier_reject_core;
    import wpm_pkg::*;

    localparam int WIN          = 5;
    localparam int CNT_W        = $clog2(WIN + 1);
    localparam int DRAIN        = 40;      // longer than the trip of one word through the block
    localparam int LIMIT        = 500000;
    localparam int RANDOM_WORDS = 426;

    // one result word as the block emits it
    typedef struct packed {
        logic signed [PT_W-1:0] mx;
        logic signed [PT_W-1:0] my;
        logic signed [PT_W-1:0] mz;
        logic [CNT_W-1:0]       cnt;
        logic                   all_in;
    } t_mean_word;

    typedef enum logic {ROW_POINT, ROW_RADIUS} t_row_kind;

    // one row of the directed table
    typedef struct {
        t_row_kind       kind;
        t_point          pt;
        logic [R_W-1:0]  radius;
        bit              typed;
        t_mean_word      want;
    } t_dir_row;

    // dut ports, all inputs known from time zero
    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_cfg_we   = 1'b0;
    logic [R_W-1:0]         i_cfg_data = '0;
    logic                   i_valid    = 1'b0;
    logic signed [PT_W-1:0] i_point_x  = '0;
    logic signed [PT_W-1:0] i_point_y  = '0;
    logic signed [PT_W-1:0] i_point_z  = '0;
    logic                   i_stall    = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic signed [PT_W-1:0] o_mean_x;
    logic signed [PT_W-1:0] o_mean_y;
    logic signed [PT_W-1:0] o_mean_z;
    logic [CNT_W-1:0]       o_inlier_count;
    logic                   o_all_inliers;

    // window tracker state and expected result words
    longint     win_c [WIN][3];
    int         fill_n     = 0;
    int         old_slot   = 0;
    longint     radius_cur = 500;
    t_mean_word mean_q [$];
    t_dir_row   dir_tab [$];

    int err_n      = 0;
    int cyc_n      = 0;
    int stall_left = 0;
    int stall_pick;
    bit calm       = 1'b0;

    windowed_point_mean_outlier_reject_core #(
        .WINDOW(WIN)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_mean_x       (o_mean_x),
        .o_mean_y       (o_mean_y),
        .o_mean_z       (o_mean_z),
        .o_inlier_count (o_inlier_count),
        .o_all_inliers  (o_all_inliers)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int pick;
        if (calm) begin
            return 0;
        end
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
            return 0;
        end else if (pick < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // window tracker: stores the point, then forms the inlier mean once full
    function automatic bit track_window_mean(input t_point p, output t_mean_word r);
        longint s [3];
        longint acc [3];
        longint d;
        longint d2;
        longint lim;
        int     n;
        int     slot;
        r = '0;
        for (int k = 0; k < 3; k++) begin
            s[k]   = 0;
            acc[k] = 0;
        end
        slot = (fill_n < WIN) ? fill_n : old_slot;
        win_c[slot][0] = $signed(p.x);
        win_c[slot][1] = $signed(p.y);
        win_c[slot][2] = $signed(p.z);
        // still filling: store only
        if (fill_n < WIN) begin
            fill_n++;
            return 1'b0;
        end
        old_slot = (old_slot + 1) % WIN;
        for (int i = 0; i < WIN; i++) begin
            for (int k = 0; k < 3; k++) begin
                s[k] += win_c[i][k];
            end
        end
        // exact test scaled by WIN^2: |WIN*p - S|^2 < (WIN*r)^2
        lim = WIN * radius_cur;
        lim = lim * lim;
        n   = 0;
        for (int i = 0; i < WIN; i++) begin
            d2 = 0;
            for (int k = 0; k < 3; k++) begin
                d   = WIN * win_c[i][k] - s[k];
                d2 += d * d;
            end
            if (d2 < lim) begin
                for (int k = 0; k < 3; k++) begin
                    acc[k] += win_c[i][k];
                end
                n++;
            end
        end
        // no inliers leaves the word all zero
        if (n != 0) begin
            r.mx     = 16'(acc[0] / n);
            r.my     = 16'(acc[1] / n);
            r.mz     = 16'(acc[2] / n);
            r.cnt    = CNT_W'(n);
            r.all_in = (n == WIN);
        end
        return 1'b1;
    endfunction

    // directed table rows
    function automatic t_dir_row pt_row(input int x, input int y, input int z);
        t_dir_row r;
        r.kind   = ROW_POINT;
        r.pt.x   = 16'(x);
        r.pt.y   = 16'(y);
        r.pt.z   = 16'(z);
        r.radius = '0;
        r.typed  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic t_dir_row pt_typed(input int x, input int y, input int z,
                                          input int mx, input int my, input int mz,
                                          input int cnt, input bit all_in);
        t_dir_row r;
        r             = pt_row(x, y, z);
        r.typed       = 1'b1;
        r.want.mx     = 16'(mx);
        r.want.my     = 16'(my);
        r.want.mz     = 16'(mz);
        r.want.cnt    = CNT_W'(cnt);
        r.want.all_in = all_in;
        return r;
    endfunction

    function automatic t_dir_row rad_row(input int radius);
        t_dir_row r;
        r        = pt_row(0, 0, 0);
        r.kind   = ROW_RADIUS;
        r.radius = R_W'(radius);
        return r;
    endfunction

    // random point: wide spread with extremes, or a cluster with a few strays
    function automatic t_point draw_point(input bit wide, input int cx, input int cy,
                                          input int cz, input int jit);
        t_point p;
        int     c [3];
        logic signed [PT_W-1:0] v [3];
        c[0] = cx;
        c[1] = cy;
        c[2] = cz;
        for (int k = 0; k < 3; k++) begin
            if (wide || $urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 5))
                    0:       v[k] = 16'sh8000;
                    1:       v[k] = 16'sh7fff;
                    default: v[k] = 16'($urandom);
                endcase
            end else begin
                v[k] = 16'(c[k] + int'($urandom_range(0, 2 * jit)) - jit);
            end
        end
        p.x = v[0];
        p.y = v[1];
        p.z = v[2];
        return p;
    endfunction

    // offer one word and hold it until taken
    task automatic send_point(input t_point p, input bit typed, input t_mean_word want);
        int         gap;
        t_mean_word r;
        gap = idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_point_x <= p.x;
        i_point_y <= p.y;
        i_point_z <= p.z;
        do @(posedge i_clk); while (o_stall);
        if (track_window_mean(p, r)) begin
            mean_q = {mean_q, (typed ? want : r)};
        end
    endtask

    // radius write once the block has gone idle
    task automatic write_radius(input logic [R_W-1:0] r);
        i_valid <= 1'b0;
        while (mean_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= r;
        @(posedge i_clk);
        radius_cur = r;
        i_cfg_we   <= 1'b0;
    endtask

    task automatic report_field(input string name, input longint want, input longint got);
        if (want != got) begin
            err_n++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // compare a taken result word with the oldest expectation
    task automatic check_result();
        t_mean_word want;
        t_mean_word got;
        got.mx     = o_mean_x;
        got.my     = o_mean_y;
        got.mz     = o_mean_z;
        got.cnt    = o_inlier_count;
        got.all_in = o_all_inliers;
        if (mean_q.size() == 0) begin
            err_n++;
            $display("%0t: unexpected word expected none got %0d %0d %0d %0d %0d",
                     $time, got.mx, got.my, got.mz, got.cnt, got.all_in);
        end else begin
            want = mean_q.pop_front();
            report_field("mean_x", want.mx, got.mx);
            report_field("mean_y", want.my, got.my);
            report_field("mean_z", want.mz, got.mz);
            report_field("inlier_count", want.cnt, got.cnt);
            report_field("all_inliers", want.all_in, got.all_in);
        end
    endtask

    // result side: check taken words and stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            check_result();
        end
        if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            stall_pick = idle_len();
            if (stall_pick == 0) begin
                i_stall <= 1'b0;
            end else begin
                i_stall    <= 1'b1;
                stall_left <= stall_pick - 1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc_n <= cyc_n + 1;
        if (cyc_n >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin
        int             sent;
        int             len;
        int             jit;
        int             cx;
        int             cy;
        int             cz;
        bit             wide;
        logic [R_W-1:0] rad;

        // fill after reset: no result, then a uniform window
        repeat (5) dir_tab = {dir_tab, pt_row(0, 0, 0)};
        dir_tab = {dir_tab, pt_typed(0, 0, 0, 0, 0, 0, 5, 1'b1)};
        repeat (4) dir_tab = {dir_tab, pt_row(32767, 32767, 32767)};
        dir_tab = {dir_tab, pt_typed(32767, 32767, 32767, 32767, 32767, 32767, 5, 1'b1)};
        repeat (4) dir_tab = {dir_tab, pt_row(-32768, -32768, -32768)};
        dir_tab = {dir_tab,
                   pt_typed(-32768, -32768, -32768, -32768, -32768, -32768, 5, 1'b1)};
        // smallest radius on a spread window: no inliers
        dir_tab = {dir_tab, rad_row(1)};
        dir_tab = {dir_tab, pt_row(1000, 0, 0)};
        dir_tab = {dir_tab, pt_row(-1000, 0, 0)};
        dir_tab = {dir_tab, pt_row(0, 1000, 0)};
        dir_tab = {dir_tab, pt_row(0, -1000, 0)};
        dir_tab = {dir_tab, pt_typed(0, 0, 1000, 0, 0, 0, 0, 1'b0)};
        // largest radius: everything is kept
        dir_tab = {dir_tab, rad_row(65535)};
        dir_tab = {dir_tab, pt_typed(0, 0, 0, -200, 0, 200, 5, 1'b1)};
        dir_tab = {dir_tab, pt_row(32767, -32768, 32767)};
        dir_tab = {dir_tab, pt_row(-32768, 32767, -32768)};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_RADIUS) begin
                write_radius(dir_tab[i].radius);
            end else begin
                send_point(dir_tab[i].pt, dir_tab[i].typed, dir_tab[i].want);
            end
        end

        // random phases, each with its own radius and point spread
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            calm = 1'b0;
            wide = ($urandom_range(0, 3) == 0);
            jit  = $urandom_range(0, 1) ? $urandom_range(1, 20) : $urandom_range(20, 2000);
            cx   = int'($urandom_range(0, 60000)) - 30000;
            cy   = int'($urandom_range(0, 60000)) - 30000;
            cz   = int'($urandom_range(0, 60000)) - 30000;
            case ($urandom_range(0, 5))
                0:       rad = 16'd1;
                1:       rad = 16'hffff;
                2:       rad = 16'($urandom_range(1, 65535));
                default: rad = 16'($urandom_range((jit > 1) ? jit / 2 : 1, 3 * jit));
            endcase
            write_radius(rad);
            calm = ($urandom_range(0, 3) == 0);
            len  = $urandom_range(20, 60);
            if (len > RANDOM_WORDS - sent) begin
                len = RANDOM_WORDS - sent;
            end
            repeat (len) begin
                send_point(draw_point(wide, cx, cy, cz, jit), 1'b0, '0);
            end
            sent += len;
        end
        i_valid <= 1'b0;

        // drain and finish
        while (mean_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (err_n == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/wpm_pkg.sv
hdl/wpm_cell.sv
hdl/wpm_div.sv
hdl/windowed_point_mean_outlier_reject_core.sv
tb/sv/tb_windowed_point_mean_outlier_reject_core.sv
